@@ design/incremental_pi_speed_controller_defines.svh @@
// Assertion macros shared by the speed controller modules.
`ifndef INCREMENTAL_PI_SPEED_CONTROLLER_DEFINES_SVH
`define INCREMENTAL_PI_SPEED_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IPSC_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ipsc: same-cycle check failed");

// Check that must hold in the cycle after reset is applied.
`define IPSC_ASSERT_AFTER_RESET(label, clk, rstn, cons) \
    label: assert property (@(posedge clk) (!rstn) |=> (cons)) \
        else $error("ipsc: post-reset check failed");

`endif

@@ design/ipsc_pkg.sv @@
// Types and constants for the incremental PI speed controller.
package ipsc_pkg;

    localparam int SPEED_W    = 16;
    localparam int ERR_W      = 17;
    localparam int DELTA_W    = 18;
    localparam int GAIN_W     = 24;
    localparam int LIMIT_W    = 13;
    localparam int FRAC_BITS  = 20;
    localparam int PROD_W     = 42;
    localparam int ACC_W      = 35;
    localparam int SUM_W      = 43;
    localparam int DUTY_W     = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd7200;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROPORTIONAL_GAIN = 2'd0,
        REG_INTEGRAL_GAIN     = 2'd1,
        REG_DUTY_LIMIT        = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki;
        logic [LIMIT_W-1:0] limit;
    } cfg_t;

    typedef struct packed {
        logic                     valid;
        logic signed [PROD_W-1:0] p_term;
        logic signed [PROD_W-1:0] i_term;
    } prod_t;

endpackage

@@ design/ipsc_cfg.sv @@
// Configuration register file: gains and duty limit.
module ipsc_cfg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ipsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ipsc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output ipsc_pkg::cfg_t                       cfg
);
    import ipsc_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;

    assign cfg_ready = 1'b1;
    assign idx       = reg_idx_t'(cfg_index);
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (idx)
                REG_PROPORTIONAL_GAIN: cfg_next.kp = cfg_data[GAIN_W-1:0];
                REG_INTEGRAL_GAIN:     cfg_next.ki = cfg_data[GAIN_W-1:0];
                REG_DUTY_LIMIT:        cfg_next.limit = cfg_data[LIMIT_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp    <= '0;
            cfg_reg.ki    <= '0;
            cfg_reg.limit <= LIMIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ design/ipsc_front.sv @@
// Input register, error and delta, and the two gain products.
`include "incremental_pi_speed_controller_defines.svh"

module ipsc_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [ipsc_pkg::SPEED_W-1:0]  s_measured_speed,
    input  logic signed [ipsc_pkg::SPEED_W-1:0]  s_target_speed,
    input  ipsc_pkg::cfg_t                       cfg,
    input  logic                                 back_ready,
    output ipsc_pkg::prod_t                      prod
);
    import ipsc_pkg::*;

    logic                      in_valid_reg;
    logic                      in_valid_next;
    logic signed [SPEED_W-1:0] measured_reg;
    logic signed [SPEED_W-1:0] target_reg;
    logic signed [ERR_W-1:0]   prev_err_reg;
    logic                      prod_valid_reg;
    logic                      prod_valid_next;
    logic signed [PROD_W-1:0]  p_term_reg;
    logic signed [PROD_W-1:0]  i_term_reg;

    logic                      prod_free;
    logic                      in_free;
    logic                      in_adv;
    logic signed [ERR_W-1:0]   err;
    logic signed [DELTA_W-1:0] delta;
    logic signed [GAIN_W:0]    kp_s;
    logic signed [GAIN_W:0]    ki_s;
    logic signed [PROD_W-1:0]  p_full;
    logic signed [PROD_W-1:0]  i_full;

    assign prod_free = !prod_valid_reg || back_ready;
    assign in_free   = !in_valid_reg || prod_free;
    assign in_adv    = in_valid_reg && prod_free;
    assign s_ready   = in_free;

    assign err   = $signed({target_reg[SPEED_W-1], target_reg})
                 - $signed({measured_reg[SPEED_W-1], measured_reg});
    assign delta = $signed({err[ERR_W-1], err})
                 - $signed({prev_err_reg[ERR_W-1], prev_err_reg});

    assign kp_s   = $signed({1'b0, cfg.kp});
    assign ki_s   = $signed({1'b0, cfg.ki});
    assign p_full = kp_s * delta;
    assign i_full = ki_s * err;

    assign in_valid_next   = in_free ? s_valid : in_valid_reg;
    assign prod_valid_next = prod_free ? in_valid_reg : prod_valid_reg;

    assign prod.valid  = prod_valid_reg;
    assign prod.p_term = p_term_reg;
    assign prod.i_term = i_term_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            prev_err_reg   <= '0;
        end else begin
            in_valid_reg   <= in_valid_next;
            prod_valid_reg <= prod_valid_next;
            if (in_adv) begin
                prev_err_reg <= err;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && in_free) begin
            measured_reg <= s_measured_speed;
            target_reg   <= s_target_speed;
        end
        if (in_adv) begin
            p_term_reg <= p_full;
            i_term_reg <= i_full;
        end
    end

    `IPSC_ASSERT_AFTER_RESET(a_front_empty_after_reset, aclk, aresetn, !in_valid_reg && !prod_valid_reg)
    `IPSC_ASSERT_IMPLY(a_ready_when_empty, aclk, aresetn, !in_valid_reg, s_ready)
    `IPSC_ASSERT_IMPLY(a_zero_kp_zero_term, aclk, aresetn, prod_valid_reg && (cfg.kp == '0), p_term_reg == '0)

endmodule

@@ design/ipsc_back.sv @@
// Accumulator with saturation and the registered duty output.
`include "incremental_pi_speed_controller_defines.svh"

module ipsc_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ipsc_pkg::cfg_t                       cfg,
    input  ipsc_pkg::prod_t                      prod,
    output logic                                 back_ready,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ipsc_pkg::DUTY_W-1:0]   m_duty
);
    import ipsc_pkg::*;

    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [DUTY_W-1:0] duty_reg;
    logic signed [DUTY_W-1:0] duty_next;

    logic                     take;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  lim_pos;
    logic signed [SUM_W-1:0]  lim_neg;
    logic signed [DUTY_W-1:0] lim_duty;
    logic signed [DUTY_W-1:0] floor_duty;
    logic                     round_up;
    logic                     over;
    logic                     under;

    assign back_ready = !out_valid_reg || m_ready;
    assign take       = prod.valid && back_ready;

    assign sum = $signed({{(SUM_W-ACC_W){acc_reg[ACC_W-1]}}, acc_reg})
               + $signed({{(SUM_W-PROD_W){prod.p_term[PROD_W-1]}}, prod.p_term})
               + $signed({{(SUM_W-PROD_W){prod.i_term[PROD_W-1]}}, prod.i_term});

    assign lim_pos  = $signed({{(SUM_W-LIMIT_W-FRAC_BITS){1'b0}}, cfg.limit,
                               {FRAC_BITS{1'b0}}});
    assign lim_neg  = -lim_pos;
    assign lim_duty = $signed({1'b0, cfg.limit});
    assign over     = sum > lim_pos;
    assign under    = sum < lim_neg;

    assign floor_duty = $signed(sum[FRAC_BITS+DUTY_W-1:FRAC_BITS]);
    assign round_up   = sum[SUM_W-1] && (|sum[FRAC_BITS-1:0]);

    always_comb begin
        priority if (over) begin
            acc_next  = lim_pos[ACC_W-1:0];
            duty_next = lim_duty;
        end else if (under) begin
            acc_next  = lim_neg[ACC_W-1:0];
            duty_next = -lim_duty;
        end else begin
            acc_next  = sum[ACC_W-1:0];
            duty_next = floor_duty + $signed({{(DUTY_W-1){1'b0}}, round_up});
        end
    end

    assign out_valid_next = back_ready ? prod.valid : out_valid_reg;

    assign m_valid = out_valid_reg;
    assign m_duty  = duty_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            duty_reg <= duty_next;
        end
    end

    `IPSC_ASSERT_IMPLY(a_duty_within_limit, aclk, aresetn, out_valid_reg, (duty_reg <= lim_duty) && (duty_reg >= -lim_duty))
    `IPSC_ASSERT_IMPLY(a_duty_sign_matches_acc, aclk, aresetn, out_valid_reg, (duty_reg == '0) || (duty_reg[DUTY_W-1] == acc_reg[ACC_W-1]))
    `IPSC_ASSERT_IMPLY(a_zero_limit_holds_acc, aclk, aresetn, out_valid_reg && (cfg.limit == '0), acc_reg == '0)

endmodule

@@ design/incremental_pi_speed_controller.sv @@
// Top level of the incremental PI motor speed controller.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+--------------------------------------
//  s_      | in        | s_valid/s_ready   | s_measured_speed, s_target_speed (Q4.12)
//  m_      | out       | m_valid/m_ready   | m_duty (signed, -8191..8191)
//  cfg_    | in        | cfg_valid/ready   | cfg_index, cfg_data
//
// One item per cycle while m_ready is high; an accepted input goes through the
// input, product and output registers to m_valid. The accumulator add and clamp
// form the feedback loop; the two gain multipliers sit in the stage before it.
// Reset is synchronous, active low; it clears the error and accumulator state and
// loads the gains with zero and the duty limit with 7200.
// A stall on m_ready backs up through the output, product and input registers.
module incremental_pi_speed_controller (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [ipsc_pkg::SPEED_W-1:0]  s_measured_speed,
    input  logic signed [ipsc_pkg::SPEED_W-1:0]  s_target_speed,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ipsc_pkg::DUTY_W-1:0]   m_duty,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ipsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ipsc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ipsc_pkg::*;

    cfg_t  cfg;
    prod_t prod;
    logic  back_ready;

    ipsc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ipsc_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_measured_speed (s_measured_speed),
        .s_target_speed   (s_target_speed),
        .cfg              (cfg),
        .back_ready       (back_ready),
        .prod             (prod)
    );

    ipsc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .prod       (prod),
        .back_ready (back_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_duty     (m_duty)
    );

endmodule

@@ sim/incremental_pi_speed_controller_tb.sv @@
// Self-checking testbench for the PI speed controller: directed table, then random phases.
`timescale 1ns / 100ps

module incremental_pi_speed_controller_tb;
    import ipsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 150;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT_RESULT = 400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int DIR_ROWS       = 25;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
    localparam logic signed [SPEED_W-1:0] SPD_MIN = 16'sh8000;
    localparam logic signed [SPEED_W-1:0] SPD_MAX = 16'sh7FFF;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        logic [CFG_IDX_W-1:0]       idx;
        logic [CFG_DATA_W-1:0]      data;
        logic signed [SPEED_W-1:0]  meas;
        logic signed [SPEED_W-1:0]  targ;
        logic                       fixed;
        logic signed [DUTY_W-1:0]   duty;
    } vec_t;

    vec_t dir_vec [DIR_ROWS] = '{
        '{ROW_ITEM, REG_PROPORTIONAL_GAIN, 24'h0, SPD_MIN, SPD_MAX, 1'b1, 14'sd0},
        '{ROW_ITEM, REG_PROPORTIONAL_GAIN, 24'h0, SPD_MAX, SPD_MIN, 1'b1, 14'sd0},
        '{ROW_ITEM, REG_PROPORTIONAL_GAIN, 24'h0, 16'shFFFF, 16'shFFFF, 1'b1, 14'sd0},
        '{ROW_CFG, REG_PROPORTIONAL_GAIN, 24'hFFFFFF, 16'sh0, 16'sh0, 1'b0, 14'sd0},
        '{ROW_CFG, REG_INTEGRAL_GAIN, 24'hFFFFFF, 16'sh0, 16'sh0, 1'b0, 14'sd0},
        '{ROW_ITEM, REG_PROPORTIONAL_GAIN, 24'h0, SPD_MIN, SPD_MAX, 1'b1, 14'sd7200},
        '{ROW_ITEM, REG_PROPORTIONAL_GAIN, 24'h0, SPD_MAX, SPD_MIN, 1'b1, -14'sd7200},
        '{ROW_CFG, REG_DUTY_LIMIT, 24'hFFFFFF, 16'sh0, 16'sh0, 1'b0, 14'sd0},
        '{ROW_ITEM, REG_PROPORTIONAL_GAIN, 24'h0, SPD_MIN, SPD_MAX, 1'b1, 14'sd8191},
        '{ROW_CFG, REG_DUTY_LIMIT, 24'h0, 16'sh0, 16'sh0, 1'b0, 14'sd0},
        '{ROW_ITEM, REG_PROPORTIONAL_GAIN, 24'h0, 16'sd12345, -16'sd2345, 1'b1, 14'sd0},
        '{ROW_CFG, REG_UNMAPPED, 24'hFFFFFF, 16'sh0, 16'sh0, 1'b0, 14'sd0},
        '{ROW_ITEM, REG_PROPORTIONAL_GAIN, 24'h0, SPD_MIN, SPD_MAX, 1'b1, 14'sd0},
        '{ROW_CFG, REG_DUTY_LIMIT, 24'd8191, 16'sh0, 16'sh0, 1'b0, 14'sd0},
        '{ROW_ITEM, REG_PROPORTIONAL_GAIN, 24'h0, SPD_MIN, SPD_MAX, 1'b1, 14'sd8191},
        '{ROW_CFG, REG_DUTY_LIMIT, 24'd100, 16'sh0, 16'sh0, 1'b0, 14'sd0},
        '{ROW_ITEM, REG_PROPORTIONAL_GAIN, 24'h0, SPD_MIN, SPD_MAX, 1'b1, 14'sd100},
        '{ROW_CFG, REG_PROPORTIONAL_GAIN, 24'h010000, 16'sh0, 16'sh0, 1'b0, 14'sd0},
        '{ROW_CFG, REG_INTEGRAL_GAIN, 24'h000800, 16'sh0, 16'sh0, 1'b0, 14'sd0},
        '{ROW_CFG, REG_DUTY_LIMIT, 24'd7200, 16'sh0, 16'sh0, 1'b0, 14'sd0},
        '{ROW_ITEM, REG_PROPORTIONAL_GAIN, 24'h0, 16'sd4096, 16'sd0, 1'b0, 14'sd0},
        '{ROW_ITEM, REG_PROPORTIONAL_GAIN, 24'h0, 16'sd0, 16'sd4096, 1'b0, 14'sd0},
        '{ROW_ITEM, REG_PROPORTIONAL_GAIN, 24'h0, 16'sd1, 16'sd0, 1'b0, 14'sd0},
        '{ROW_ITEM, REG_PROPORTIONAL_GAIN, 24'h0, 16'sd0, 16'sd0, 1'b0, 14'sd0},
        '{ROW_ITEM, REG_PROPORTIONAL_GAIN, 24'h0, SPD_MIN, SPD_MIN, 1'b0, 14'sd0}
    };

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic signed [SPEED_W-1:0]   s_measured_speed;
    logic signed [SPEED_W-1:0]   s_target_speed;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [DUTY_W-1:0]    m_duty;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;

    logic [GAIN_W-1:0]           gain_p;
    logic [GAIN_W-1:0]           gain_i;
    logic [LIMIT_W-1:0]          duty_bound;
    logic signed [ERR_W-1:0]     last_err;
    longint                      integ_acc;

    logic signed [DUTY_W-1:0]    duty_q[$];
    int                          fail_count = 0;
    int                          results_done = 0;
    int                          quiet_cycles = 0;
    logic                        sender_steady = 1'b0;

    always #5 aclk = ~aclk;

    incremental_pi_speed_controller DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_measured_speed (s_measured_speed),
        .s_target_speed   (s_target_speed),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_duty           (m_duty),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [DUTY_W-1:0] pi_duty_step(
        input logic signed [SPEED_W-1:0] meas,
        input logic signed [SPEED_W-1:0] targ
    );
        longint e;
        longint d;
        longint sum;
        longint bound;
        longint whole;
        e     = longint'(targ) - longint'(meas);
        d     = e - longint'(last_err);
        sum   = integ_acc + longint'(gain_p) * d + longint'(gain_i) * e;
        bound = longint'(duty_bound) <<< FRAC_BITS;
        if (sum > bound) begin
            sum = bound;
        end
        if (sum < -bound) begin
            sum = -bound;
        end
        integ_acc = sum;
        last_err  = e[ERR_W-1:0];
        whole = (sum >= 0) ? (sum >>> FRAC_BITS) : -((-sum) >>> FRAC_BITS);
        return whole[DUTY_W-1:0];
    endfunction

    task automatic offer_speeds(
        input logic signed [SPEED_W-1:0] meas,
        input logic signed [SPEED_W-1:0] targ,
        input logic                      fixed,
        input logic signed [DUTY_W-1:0]  duty
    );
        int gap;
        logic signed [DUTY_W-1:0] want;
        @(negedge aclk);
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_measured_speed <= meas;
        s_target_speed   <= targ;
        do @(posedge aclk); while (!s_ready);
        want = pi_duty_step(meas, targ);
        duty_q.push_back(fixed ? duty : want);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_PROPORTIONAL_GAIN: gain_p = data;
            REG_INTEGRAL_GAIN:     gain_i = data;
            REG_DUTY_LIMIT:        duty_bound = data[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (duty_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_gain(input logic [CFG_DATA_W-1:0] span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return '0;
        end else if (r < 20) begin
            return '1;
        end
        return CFG_DATA_W'($urandom_range(0, span));
    endfunction

    initial begin
        int k;
        int p;
        int n;
        int r;
        int trk_meas;
        int trk_targ;
        logic signed [SPEED_W-1:0] meas;
        logic signed [SPEED_W-1:0] targ;
        logic [CFG_DATA_W-1:0] lim_data;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_measured_speed = '0;
        s_target_speed   = '0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        gain_p           = '0;
        gain_i           = '0;
        duty_bound       = LIMIT_RESET;
        last_err         = '0;
        integ_acc        = 0;
        trk_meas         = 0;
        trk_targ         = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < DIR_ROWS; k++) begin
            if (dir_vec[k].kind == ROW_CFG) begin
                settle();
                write_reg(dir_vec[k].idx, dir_vec[k].data);
            end else begin
                offer_speeds(dir_vec[k].meas, dir_vec[k].targ, dir_vec[k].fixed,
                             dir_vec[k].duty);
            end
        end

        for (p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            write_reg(REG_PROPORTIONAL_GAIN, pick_gain(24'h0FFFFF));
            write_reg(REG_INTEGRAL_GAIN, pick_gain(24'h03FFFF));
            lim_data = CFG_DATA_W'($urandom);
            r = $urandom_range(0, 9);
            lim_data[LIMIT_W-1:0] = (r == 0) ? '0 : (r == 1) ? '1
                                  : LIMIT_W'($urandom_range(1, 8191));
            write_reg(REG_DUTY_LIMIT, lim_data);
            if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
            end
            sender_steady = (p % 3 == 0);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    meas = SPEED_W'($urandom);
                    targ = SPEED_W'($urandom);
                end else if (r < 16) begin
                    meas = $urandom_range(0, 1) ? SPD_MAX : SPD_MIN;
                    targ = $urandom_range(0, 1) ? SPD_MAX : SPD_MIN;
                end else begin
                    if ($urandom_range(0, 9) == 0) begin
                        targ = SPEED_W'($urandom);
                        trk_targ = targ;
                    end
                    trk_meas = trk_meas + (trk_targ - trk_meas) / 4
                               + int'($urandom_range(0, 400)) - 200;
                    if (trk_meas > 32767) begin
                        trk_meas = 32767;
                    end
                    if (trk_meas < -32768) begin
                        trk_meas = -32768;
                    end
                    meas = SPEED_W'(trk_meas);
                    targ = SPEED_W'(trk_targ);
                end
                offer_speeds(meas, targ, 1'b0, '0);
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        int stall_left;
        int g;
        logic steady;
        logic hold_done;
        stall_left = 0;
        steady     = 1'b0;
        hold_done  = 1'b0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 149) == 0) begin
                steady = !steady;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (results_done >= HOLD_AT_RESULT && !hold_done) begin
                m_ready <= 1'b0;
                stall_left = HOLD_CYCLES - 1;
                hold_done = 1'b1;
            end else begin
                g = (!steady && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
                if (g > 0) begin
                    m_ready <= 1'b0;
                    stall_left = g - 1;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin : duty_check
        logic signed [DUTY_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            results_done++;
            if (duty_q.size() == 0) begin
                $display("%0t: unexpected duty item, expected none, actual %0d", $time, m_duty);
                fail_count++;
            end else begin
                want = duty_q.pop_front();
                if (want !== m_duty) begin
                    $display("%0t: duty mismatch, expected %0d, actual %0d", $time, want, m_duty);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
